>>> rtl/bpl_pkg.sv
// Package for the bounded positional list: depth, derived widths, command codes,
// beat payload structs and the control struct shared by the decoder and the cells.
// Depends on nothing.
package bpl_pkg;

  localparam int unsigned Depth = 16;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned PosW  = 4;
  localparam int unsigned DataW = 32;
  localparam int unsigned CmpW  = ((CntW > PosW) ? CntW : PosW) + 1;

  typedef enum logic [2:0] {
    CmdPushFront   = 3'd0,
    CmdAppendBack  = 3'd1,
    CmdInsertAt    = 3'd2,
    CmdRemoveAfter = 3'd3,
    CmdPopFront    = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [2:0]              cmd;
    logic signed [DataW-1:0] item_value;
    logic [PosW-1:0]         position;
  } in_item_t;

  typedef struct packed {
    logic                    ok;
    logic signed [DataW-1:0] removed_item;
    logic [CntW-1:0]         list_size;
  } out_item_t;

  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [IdxW-1:0]  idx;
    logic [DataW-1:0] value;
  } cell_ctl_t;

endpackage

>>> rtl/bpl_cell.sv
// One list slot: holds a single entry and shifts towards its neighbours.
// Depends on bpl_pkg.
module bpl_cell
  import bpl_pkg::*;
(
  input  logic             clk_i,
  input  logic [IdxW-1:0]  cell_idx_i,
  input  cell_ctl_t        ctl_i,
  input  logic [DataW-1:0] left_i,
  input  logic [DataW-1:0] right_i,
  output logic [DataW-1:0] value_o
);

  logic [DataW-1:0] value_q, value_d;

  always_comb begin
    value_d = value_q;
    if (ctl_i.ins) begin
      if (cell_idx_i == ctl_i.idx) begin
        value_d = ctl_i.value;
      end else if (cell_idx_i > ctl_i.idx) begin
        value_d = left_i;
      end
    end else if (ctl_i.rem) begin
      if (cell_idx_i >= ctl_i.idx) begin
        value_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

>>> rtl/bpl_ctrl.sv
// Command decoder and size counter: checks each command against the size and
// drives the shift controls for the cell row. Depends on bpl_pkg.
module bpl_ctrl
  import bpl_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  in_item_t        item_i,
  output cell_ctl_t       ctl_o,
  output logic            ok_o,
  output logic [CntW-1:0] size_o
);

  logic [CntW-1:0] count_q, count_d;
  logic [CmpW-1:0] pos_w, pos1_w, cnt_w;
  logic            full, empty, ins, rem, ok;
  logic [IdxW-1:0] idx;

  assign pos_w  = CmpW'(item_i.position);
  assign pos1_w = pos_w + CmpW'(1);
  assign cnt_w  = CmpW'(count_q);
  assign full   = (count_q == CntW'(Depth));
  assign empty  = (count_q == '0);

  always_comb begin
    ins = 1'b0;
    rem = 1'b0;
    ok  = 1'b0;
    idx = '0;
    unique case (item_i.cmd)
      CmdPushFront: begin
        ins = 1'b1;
        ok  = !full;
      end
      CmdAppendBack: begin
        ins = 1'b1;
        ok  = !full;
        idx = count_q[IdxW-1:0];
      end
      CmdInsertAt: begin
        ins = 1'b1;
        ok  = !full && !empty && (pos_w < cnt_w);
        idx = pos_w[IdxW-1:0];
      end
      CmdRemoveAfter: begin
        rem = 1'b1;
        ok  = (pos1_w < cnt_w);
        idx = pos1_w[IdxW-1:0];
      end
      CmdPopFront: begin
        rem = 1'b1;
        ok  = !empty;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (fire_i && ok && ins) begin
      count_d = count_q + CntW'(1);
    end else if (fire_i && ok && rem) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign ctl_o.ins   = fire_i && ok && ins;
  assign ctl_o.rem   = fire_i && ok && rem;
  assign ctl_o.idx   = idx;
  assign ctl_o.value = item_i.item_value;
  assign ok_o        = ok;
  assign size_o      = count_d;

endmodule

>>> rtl/bounded_positional_list_unit.sv
// Bounded positional list: a row of Depth cells with insert/remove at any slot.
// Each accepted input beat yields its result beat in the next cycle, held in an output register.
// Throughput: one command per cycle while the result register is free or being emptied;
// each cell shifts or holds on a single index compare, so the row settles in the accepting cycle.
// Reset (rst_ni, async, active low) empties the list and drops any pending result;
// cell contents stay undefined until written and are never read beyond the size.
module bounded_positional_list_unit
  import bpl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic             fire;
  cell_ctl_t        ctl;
  logic             ok;
  logic [CntW-1:0]  size;
  logic [DataW-1:0] cell_val [Depth];
  logic [DataW-1:0] rd_val;

  logic      out_valid_q;
  out_item_t out_data_q, out_data_d;

  // Take a new beat whenever the result register is free or being emptied.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  bpl_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_data_i),
    .ctl_o  (ctl),
    .ok_o   (ok),
    .size_o (size)
  );

  // Cell row: each slot sees its left and right neighbour; the ends see zero.
  for (genvar g = 0; g < Depth; g++) begin : g_cell
    logic [DataW-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_inner_l
      assign left = cell_val[g-1];
    end
    if (g == Depth - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner_r
      assign right = cell_val[g+1];
    end

    bpl_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (IdxW'(g)),
      .ctl_i      (ctl),
      .left_i     (left),
      .right_i    (right),
      .value_o    (cell_val[g])
    );
  end

  // The slot being removed, read before the row shifts over it.
  assign rd_val = cell_val[ctl.idx];

  always_comb begin
    out_data_d.ok           = ok;
    out_data_d.removed_item = ctl.rem ? rd_val : '0;
    out_data_d.list_size    = size;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold the result while it waits; load only on an accepted beat.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> rtl/bpl_checker.sv
// Port-level checks for the bounded positional list, bound to the top level.
// Depends on bpl_pkg and bounded_positional_list_unit.
module bpl_checker
  import bpl_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  // A stalled result beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // Every accepted command yields a result beat in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted beat produced no result");

  // The size never exceeds the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.list_size <= CntW'(Depth))
    else $error("list size beyond capacity");

  // A rejected command removes nothing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.ok |-> out_data_o.removed_item == '0)
    else $error("rejected command returned an item");

endmodule

bind bounded_positional_list_unit bpl_checker u_bpl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
